/* rtl/core/dshot4_pkg.sv */
// shared types and constants of the four-line dshot transmitter
package dshot4_pkg;

	localparam int LINES      = 4;
	localparam int FRAME_LEN  = 16;
	localparam int THR_W      = 16;
	localparam int VAL_W      = 11;
	localparam int TICK_W     = 8;
	localparam int POS_W      = 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic [VAL_W-1:0] THROTTLE_MAX = 11'd2047;
	localparam logic [VAL_W-1:0] THROTTLE_MIN = 11'd48;
	localparam logic [POS_W-1:0] LAST_POS     = 4'd15;

	localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 2'd2;

	localparam logic [TICK_W-1:0] RST_BIT_PERIOD = 8'd107;
	localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 8'd78;
	localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 8'd39;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [THR_W-1:0] throttle_0;
		logic [THR_W-1:0] throttle_1;
		logic [THR_W-1:0] throttle_2;
		logic [THR_W-1:0] throttle_3;
		logic [LINES-1:0] telemetry_mask;
	} in_t;

	typedef struct packed {
		logic [LINES-1:0] line_levels;
		logic             busy_res;
		logic             load_rejected;
		logic             frame_done;
	} out_t;

	typedef struct packed {
		logic [TICK_W-1:0] bit_period;
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] zero_high;
	} cfg_t;

	typedef logic [LINES-1:0][FRAME_LEN-1:0] frames_t;

endpackage

/* rtl/core/dshot_four_channel_transmitter_top.sv */
// top level of the four-line dshot transmitter
// an accepted beat is registered in stage 1, then its result in the result register
// throughput: one beat per clock unless out_stall holds; both registers advance on go
// input stalls only while stage 1 holds a beat and the result register waits on out_stall
// asynchronous active-low reset clears the frame state, the valid bits and
// restores the timing registers to 107, 78 and 39 ticks
module dshot_four_channel_transmitter_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dshot4_pkg::in_t                    in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dshot4_pkg::out_t                   out_data,
	input  logic                               cfg_we,
	input  logic [dshot4_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dshot4_pkg::TICK_W-1:0]      cfg_data
);

	dshot4_pkg::cfg_t    cfg_q;
	dshot4_pkg::in_t     item_s1;
	logic                valid_s1;
	logic                go;
	dshot4_pkg::frames_t frames;
	dshot4_pkg::out_t    result;
	dshot4_pkg::out_t    out_q;
	logic                out_valid_q;

	assign go       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period <= dshot4_pkg::RST_BIT_PERIOD;
			cfg_q.one_high   <= dshot4_pkg::RST_ONE_HIGH;
			cfg_q.zero_high  <= dshot4_pkg::RST_ZERO_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dshot4_pkg::CFG_BIT_PERIOD: cfg_q.bit_period <= cfg_data;
				dshot4_pkg::CFG_ONE_HIGH:   cfg_q.one_high   <= cfg_data;
				dshot4_pkg::CFG_ZERO_HIGH:  cfg_q.zero_high  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	dshot4_encoder u_encoder (
		.item   (item_s1),
		.frames (frames)
	);

	dshot4_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.frames (frames),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/core/dshot4_encoder.sv */
// builds the four 16-bit frames from one load beat
module dshot4_encoder (
	input  dshot4_pkg::in_t     item,
	output dshot4_pkg::frames_t frames
);

	function automatic logic [dshot4_pkg::FRAME_LEN-1:0] build_frame(
		input logic [dshot4_pkg::THR_W-1:0] thr,
		input logic                         tlm
	);
		logic [dshot4_pkg::VAL_W-1:0] v;
		logic [11:0]                  word;
		logic [3:0]                   chk;
		begin
			if (thr > {{(dshot4_pkg::THR_W-dshot4_pkg::VAL_W){1'b0}}, dshot4_pkg::THROTTLE_MAX})
				v = dshot4_pkg::THROTTLE_MAX;
			else
				v = thr[dshot4_pkg::VAL_W-1:0];
			if (v < dshot4_pkg::THROTTLE_MIN)
				v = '0;
			word = {v, tlm};
			chk  = word[3:0] ^ word[7:4] ^ word[11:8];
			build_frame = {word, chk};
		end
	endfunction

	assign frames[0] = build_frame(item.throttle_0, item.telemetry_mask[0]);
	assign frames[1] = build_frame(item.throttle_1, item.telemetry_mask[1]);
	assign frames[2] = build_frame(item.throttle_2, item.telemetry_mask[2]);
	assign frames[3] = build_frame(item.throttle_3, item.telemetry_mask[3]);

endmodule

/* rtl/core/dshot4_engine.sv */
// frame state, bit timing and per-beat result logic
module dshot4_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  dshot4_pkg::in_t     item,
	input  dshot4_pkg::frames_t frames,
	input  dshot4_pkg::cfg_t    cfg,
	output dshot4_pkg::out_t    result
);

	dshot4_pkg::frames_t             frame_q, frame_d;
	logic [dshot4_pkg::POS_W-1:0]    pos_q, pos_d;
	logic [dshot4_pkg::TICK_W-1:0]   tick_q, tick_d;
	logic                            sending_q, sending_d;
	logic [dshot4_pkg::LINES-1:0]    levels;
	logic [dshot4_pkg::TICK_W:0]     tick_nxt;

	always_comb begin
		logic [dshot4_pkg::TICK_W-1:0] high;
		for (int i = 0; i < dshot4_pkg::LINES; i++) begin
			high = frame_q[i][dshot4_pkg::FRAME_LEN-1] ? cfg.one_high : cfg.zero_high;
			levels[i] = sending_q && (tick_q < high);
		end
	end

	assign tick_nxt = {1'b0, tick_q} + {{dshot4_pkg::TICK_W{1'b0}}, 1'b1};

	always_comb begin
		frame_d   = frame_q;
		pos_d     = pos_q;
		tick_d    = tick_q;
		sending_d = sending_q;
		result    = '0;
		if (item.mode == dshot4_pkg::MODE_LOAD) begin
			if (sending_q) begin
				result.line_levels   = levels;
				result.load_rejected = 1'b1;
			end else begin
				frame_d   = frames;
				pos_d     = '0;
				tick_d    = '0;
				sending_d = 1'b1;
			end
		end else if (sending_q) begin
			result.line_levels = levels;
			if (tick_nxt >= {1'b0, cfg.bit_period}) begin
				tick_d = '0;
				if (pos_q == dshot4_pkg::LAST_POS) begin
					pos_d             = '0;
					sending_d         = 1'b0;
					result.frame_done = 1'b1;
				end else begin
					pos_d = pos_q + 1'b1;
					for (int i = 0; i < dshot4_pkg::LINES; i++)
						frame_d[i] = {frame_q[i][dshot4_pkg::FRAME_LEN-2:0], 1'b0};
				end
			end else begin
				tick_d = tick_nxt[dshot4_pkg::TICK_W-1:0];
			end
		end
		result.busy_res = sending_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			pos_q     <= '0;
			tick_q    <= '0;
			sending_q <= 1'b0;
		end else if (go) begin
			frame_q   <= frame_d;
			pos_q     <= pos_d;
			tick_q    <= tick_d;
			sending_q <= sending_d;
		end
	end

endmodule

/* rtl/core/dshot4_checker.sv */
// port-level checks of the four-line dshot transmitter and their bind
module dshot4_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input dshot4_pkg::in_t                  in_data,
	input logic                             out_valid,
	input logic                             out_stall,
	input dshot4_pkg::out_t                 out_data,
	input logic                             cfg_we,
	input logic [dshot4_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dshot4_pkg::TICK_W-1:0]    cfg_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.load_rejected |-> out_data.busy_res && !out_data.frame_done)
		else $error("rejected load while not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> !out_data.busy_res)
		else $error("frame done while still busy");

	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.busy_res && !out_data.frame_done |-> out_data.line_levels == '0)
		else $error("lines driven while idle");

endmodule

bind dshot_four_channel_transmitter_top dshot4_checker u_dshot4_checker (.*);

/* bench/dshot_four_channel_transmitter_checker.sv */
// checker for the four-line dshot transmitter: predicts every result beat and compares
module dshot_four_channel_transmitter_checker
	import dshot4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_t                  in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [TICK_W-1:0] period_cfg;
	logic [TICK_W-1:0] one_cfg;
	logic [TICK_W-1:0] zero_cfg;
	logic [LINES-1:0]  frame_cols [FRAME_LEN];
	logic [POS_W-1:0]  bit_pos;
	logic [TICK_W-1:0] tick_cnt;
	logic              sending;
	out_t              tx_results_q [$];
	int                errs;

	function automatic logic [FRAME_LEN-1:0] dshot_word(input logic [THR_W-1:0] thr,
			input logic tlm);
		logic [VAL_W-1:0] val;
		logic [11:0]      word;
		val = (thr > THR_W'(THROTTLE_MAX)) ? THROTTLE_MAX : thr[VAL_W-1:0];
		if (val < THROTTLE_MIN) begin
			val = '0;
		end
		word = {val, tlm};
		return {word, word[3:0] ^ word[7:4] ^ word[11:8]};
	endfunction

	function automatic logic [LINES-1:0] levels_now();
		logic [LINES-1:0]  lv;
		logic [LINES-1:0]  col;
		logic [TICK_W-1:0] hi;
		lv = '0;
		if (sending) begin
			col = frame_cols[bit_pos];
			for (int i = 0; i < LINES; i++) begin
				hi = col[i] ? one_cfg : zero_cfg;
				if (tick_cnt < hi) begin
					lv[i] = 1'b1;
				end
			end
		end
		return lv;
	endfunction

	function automatic out_t transmit_step(input in_t beat);
		out_t               res;
		logic [FRAME_LEN-1:0] words [LINES];
		logic [TICK_W:0]    nxt;
		res = '0;
		if (beat.mode == MODE_LOAD) begin
			if (sending) begin
				res.load_rejected = 1'b1;
				res.line_levels = levels_now();
			end else begin
				words[0] = dshot_word(beat.throttle_0, beat.telemetry_mask[0]);
				words[1] = dshot_word(beat.throttle_1, beat.telemetry_mask[1]);
				words[2] = dshot_word(beat.throttle_2, beat.telemetry_mask[2]);
				words[3] = dshot_word(beat.throttle_3, beat.telemetry_mask[3]);
				for (int j = 0; j < FRAME_LEN; j++) begin
					for (int i = 0; i < LINES; i++) begin
						frame_cols[j][i] = words[i][FRAME_LEN-1-j];
					end
				end
				bit_pos = '0;
				tick_cnt = '0;
				sending = 1'b1;
			end
		end else if (sending) begin
			res.line_levels = levels_now();
			nxt = {1'b0, tick_cnt} + 1'b1;
			if (nxt >= {1'b0, period_cfg}) begin
				tick_cnt = '0;
				if (bit_pos == LAST_POS) begin
					bit_pos = '0;
					sending = 1'b0;
					res.frame_done = 1'b1;
				end else begin
					bit_pos = bit_pos + 1'b1;
				end
			end else begin
				tick_cnt = nxt[TICK_W-1:0];
			end
		end
		res.busy_res = sending;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			period_cfg = RST_BIT_PERIOD;
			one_cfg = RST_ONE_HIGH;
			zero_cfg = RST_ZERO_HIGH;
			for (int j = 0; j < FRAME_LEN; j++) begin
				frame_cols[j] = '0;
			end
			bit_pos = '0;
			tick_cnt = '0;
			sending = 1'b0;
			tx_results_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BIT_PERIOD: period_cfg = cfg_data;
					CFG_ONE_HIGH:   one_cfg = cfg_data;
					CFG_ZERO_HIGH:  zero_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				tx_results_q.push_back(transmit_step(in_data));
			end
			if (out_valid && !out_stall) begin
				if (tx_results_q.size() == 0) begin
					errs++;
					if (errs <= 10) begin
						$display("%t unexpected beat: levels=%b busy=%b rej=%b done=%b", $realtime,
							out_data.line_levels, out_data.busy_res, out_data.load_rejected,
							out_data.frame_done);
					end
				end else begin
					want = tx_results_q.pop_front();
					if (out_data.line_levels !== want.line_levels ||
							out_data.busy_res !== want.busy_res ||
							out_data.load_rejected !== want.load_rejected ||
							out_data.frame_done !== want.frame_done) begin
						errs++;
						if (errs <= 10) begin
							$display("%t mismatch: expected levels=%b busy=%b rej=%b done=%b",
								$realtime, want.line_levels, want.busy_res, want.load_rejected,
								want.frame_done);
							$display("%t           actual   levels=%b busy=%b rej=%b done=%b",
								$realtime, out_data.line_levels, out_data.busy_res,
								out_data.load_rejected, out_data.frame_done);
						end
					end
				end
			end
			fail_count <= errs;
			pending <= tx_results_q.size();
		end
	end

endmodule

/* bench/dshot_four_channel_transmitter_top_tb.sv */
// stimulus and verdict for the four-line dshot transmitter testbench
module dshot_four_channel_transmitter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dshot4_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data = '0;
	int                   fail_count;
	int                   pending;
	int                   send_idle_pct = 20;
	int                   recv_idle_pct = 55;
	int                   ticks_left = 0;
	int                   bit_ticks = 107;

	dshot_four_channel_transmitter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dshot_four_channel_transmitter_checker frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [THR_W-1:0] rand_throttle();
		case ($urandom_range(4))
			0: return THR_W'($urandom_range(47));
			1: return THR_W'($urandom_range(2047, 48));
			2: return THR_W'($urandom_range(65535, 2048));
			3: begin
				case ($urandom_range(5))
					0:       return 16'd0;
					1:       return 16'd47;
					2:       return 16'd48;
					3:       return 16'd2047;
					4:       return 16'd2048;
					default: return 16'hFFFF;
				endcase
			end
			default: return THR_W'($urandom);
		endcase
	endfunction

	function automatic in_t rand_beat(input logic mode);
		in_t b;
		b.mode = mode;
		b.throttle_0 = rand_throttle();
		b.throttle_1 = rand_throttle();
		b.throttle_2 = rand_throttle();
		b.throttle_3 = rand_throttle();
		b.telemetry_mask = LINES'($urandom);
		return b;
	endfunction

	task automatic send_beat(input in_t beat);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timing(input logic [TICK_W-1:0] per, input logic [TICK_W-1:0] one_hi,
			input logic [TICK_W-1:0] zero_hi);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BIT_PERIOD;
		cfg_data <= per;
		@(posedge clk);
		cfg_index <= CFG_ONE_HIGH;
		cfg_data <= one_hi;
		@(posedge clk);
		cfg_index <= CFG_ZERO_HIGH;
		cfg_data <= zero_hi;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= TICK_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("** dshot_four_channel_transmitter_top: FAILED **");
		$finish;
	end

	initial begin
		in_t               beat;
		logic [TICK_W-1:0] per;
		logic [TICK_W-1:0] one_hi;
		logic [TICK_W-1:0] zero_hi;
		logic              mode;
		int                n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// tick while idle, then extreme throttles, then a load while busy
		send_beat(rand_beat(MODE_TICK));
		beat = '{MODE_LOAD, 16'd0, 16'd47, 16'd48, 16'hFFFF, 4'b1010};
		send_beat(beat);
		ticks_left = FRAME_LEN * bit_ticks;
		beat = '{MODE_LOAD, 16'd2047, 16'd2048, 16'd49, 16'd46, 4'b0101};
		send_beat(beat);
		repeat (4) begin
			send_beat(rand_beat(MODE_TICK));
			ticks_left--;
		end

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin
					per = RST_BIT_PERIOD;
					one_hi = RST_ONE_HIGH;
					zero_hi = RST_ZERO_HIGH;
				end
				1: begin per = 8'd3;   one_hi = 8'd2;   zero_hi = 8'd1;   end
				2: begin per = 8'd255; one_hi = 8'd254; zero_hi = 8'd253; end
				3: begin per = 8'd1;   one_hi = 8'd1;   zero_hi = 8'd0;   end
				4: begin per = 8'd0;   one_hi = 8'd0;   zero_hi = 8'd5;   end
				5: begin per = 8'd6;   one_hi = 8'd200; zero_hi = 8'd3;   end
				default: begin
					per = TICK_W'($urandom_range(12, 3));
					one_hi = TICK_W'($urandom_range(per + 2, 2));
					zero_hi = TICK_W'($urandom_range(one_hi, 1));
				end
			endcase
			n = (ph == 0) ? 160 : ((ph == 3 || ph == 4) ? 80 : 120);
			if (ph != 0) begin
				drain();
				set_timing(per, one_hi, zero_hi);
			end
			if (ph < 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 55;
			end else if (ph < 6) begin
				send_idle_pct = 55;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			bit_ticks = (per < 2) ? 1 : int'(per);
			repeat (n) begin
				if (ticks_left == 0) begin
					mode = ($urandom_range(99) < 85) ? MODE_LOAD : MODE_TICK;
				end else begin
					mode = ($urandom_range(99) < 3) ? MODE_LOAD : MODE_TICK;
				end
				send_beat(rand_beat(mode));
				if (mode == MODE_LOAD && ticks_left == 0) begin
					ticks_left = FRAME_LEN * bit_ticks;
				end else if (mode == MODE_TICK && ticks_left > 0) begin
					ticks_left--;
				end
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("** dshot_four_channel_transmitter_top: PASSED **");
		end else begin
			$display("** dshot_four_channel_transmitter_top: FAILED **");
		end
		$finish;
	end

endmodule
